FILE: src/skbs_pkg.sv
// shared types, constants and codes for the sorted key table search block
// no dependencies; imported by every module of the block but skbs_ram
package skbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = ADDR_W + 1;
    localparam int COUNT_W     = 9;
    localparam int KEY_W       = 24;
    localparam int SKEY_W      = 32;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  entry_index;
        logic [7:0]  entry_upper;
        logic [15:0] entry_lower;
        logic [15:0] search_high;
        logic [7:0]  search_low;
    } item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] position;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic write_entry;
        logic load_search;
        logic probe_read;
        logic probe_step;
        logic emit_found;
        logic emit_miss;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic key_hit;
        logic range_done;
    } dp_stat_t;

endpackage

FILE: src/skbs_ram.sv
// generic single port ram with registered read data
// no dependencies
module skbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/skbs_ctrl.sv
// control state machine for the sorted key table search
// depends on skbs_pkg
module skbs_ctrl
    import skbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       action,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && action == ACT_SEARCH && !stat.count_zero)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.key_hit || stat.range_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.emit_miss = 1'b1;
                    end
                    else
                    begin
                        cmd.load_search = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.probe_read = 1'b1;
            end
            ST_CMP:
            begin
                if (stat.key_hit)
                begin
                    cmd.emit_found = 1'b1;
                end
                else if (stat.range_done)
                begin
                    cmd.emit_miss = 1'b1;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(state_reg) == ST_READ || $past(state_reg) == ST_CMP)
        else $error("compare state entered without a table read");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_found && cmd.emit_miss))
        else $error("found and miss both signaled");

    a_read_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> $past(cmd.load_search))
        else $error("read state without a search load");

endmodule

FILE: src/skbs_dp.sv
// datapath: key table, search bounds, count register and result register
// depends on skbs_pkg and skbs_ram
module skbs_dp
    import skbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic               count_we,
    input  logic [COUNT_W-1:0] count_wdata,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    output result_t            result,
    output logic               done
);

    logic [COUNT_W-1:0] count_reg;
    logic [SKEY_W-1:0]  key_reg;
    logic [BOUND_W-1:0] lo_reg;
    logic [BOUND_W-1:0] lo_next;
    logic [BOUND_W-1:0] hi1_reg;   // one past the upper bound
    logic [BOUND_W-1:0] hi1_next;
    logic [ADDR_W-1:0]  probe_mid_reg;
    logic               done_reg;
    result_t            result_reg;

    logic [BOUND_W-1:0] hi1_load;
    logic [BOUND_W-1:0] sum_cur;
    logic [BOUND_W-1:0] sum_next;
    logic [ADDR_W-1:0]  mid_cur;
    logic [ADDR_W-1:0]  mid_next;
    logic [ADDR_W-1:0]  ram_addr;
    logic [KEY_W-1:0]   ram_rdata;
    logic [SKEY_W-1:0]  probe_key;
    logic               key_gt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (count_we)
            begin
                count_reg <= count_wdata;
            end
            done_reg <= cmd.emit_found | cmd.emit_miss;
        end
    end

    assign hi1_load = (count_reg > COUNT_W'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH)
                                                          : BOUND_W'(count_reg);

    // midpoint rounded down over the inclusive range lo .. hi1-1
    assign sum_cur  = lo_reg + hi1_reg - BOUND_W'(1);
    assign mid_cur  = sum_cur[BOUND_W-1:1];

    assign probe_key = {{(SKEY_W-KEY_W){1'b0}}, ram_rdata};
    assign key_gt    = probe_key > key_reg;

    always_comb
    begin
        lo_next  = lo_reg;
        hi1_next = hi1_reg;
        if (key_gt)
        begin
            hi1_next = BOUND_W'(probe_mid_reg);
        end
        else
        begin
            lo_next = BOUND_W'(probe_mid_reg) + BOUND_W'(1);
        end
    end

    assign sum_next = lo_next + hi1_next - BOUND_W'(1);
    assign mid_next = sum_next[BOUND_W-1:1];

    always_ff @(posedge clk)
    begin
        if (cmd.load_search)
        begin
            key_reg <= {item.search_high, 16'h0000} | {24'h000000, item.search_low};
            lo_reg  <= '0;
            hi1_reg <= hi1_load;
        end
        else if (cmd.probe_step)
        begin
            lo_reg  <= lo_next;
            hi1_reg <= hi1_next;
        end
        if (cmd.probe_read)
        begin
            probe_mid_reg <= mid_cur;
        end
        else if (cmd.probe_step)
        begin
            probe_mid_reg <= mid_next;
        end
        if (cmd.emit_found || cmd.emit_miss)
        begin
            result_reg.found    <= cmd.emit_found;
            result_reg.position <= cmd.emit_found ? 8'(probe_mid_reg) : 8'h00;
        end
    end

    always_comb
    begin
        if (cmd.write_entry)
        begin
            ram_addr = ADDR_W'(item.entry_index);
        end
        else if (cmd.probe_step)
        begin
            ram_addr = mid_next;
        end
        else
        begin
            ram_addr = mid_cur;
        end
    end

    skbs_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.write_entry),
        .re    (cmd.probe_read | cmd.probe_step),
        .addr  (ram_addr),
        .wdata ({item.entry_upper, item.entry_lower}),
        .rdata (ram_rdata)
    );

    assign stat.count_zero = (count_reg == '0);
    assign stat.key_hit    = (probe_key == key_reg);
    assign stat.range_done = !(lo_next < hi1_next);

    assign result = result_reg;
    assign done   = done_reg;

    a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_read |-> lo_reg < hi1_reg)
        else $error("probe issued on an empty range");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !result_reg.found |-> result_reg.position == 8'h00)
        else $error("miss reported with nonzero position");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_step |-> BOUND_W'(mid_next) >= lo_next && BOUND_W'(mid_next) < hi1_next)
        else $error("next probe outside the search range");

endmodule

FILE: src/sorted_key_table_binary_search.sv
// search: ST_READ reads the key table, ST_CMP compares and reads the next probe until
// a hit or an empty range (1 to 9 probes); busy is high in both; done follows the last
// compare; one probe per cycle on the single port key table; writes land on accept;
// a zero count answers not found in the next cycle; the receiver cannot stall
// rst_n clears the count and control; table contents are undefined until written
// depends on skbs_pkg, skbs_ctrl, skbs_dp
module sorted_key_table_binary_search
    import skbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  item_t              item,
    input  logic               count_we,
    input  logic [COUNT_W-1:0] count_wdata,
    output logic               done,
    output result_t            result
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    skbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    skbs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .count_we    (count_we),
        .count_wdata (count_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result),
        .done        (done)
    );

endmodule

FILE: tb/testbench.sv
// self-checking bench for sorted_key_table_binary_search: table writes, count
// settings and lookups, predicted in-bench; depends on skbs_pkg and the block rtl
module testbench;
    import skbs_pkg::*;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    item_t               item        = '0;
    logic                count_we    = 1'b0;
    logic [COUNT_W-1:0]  count_wdata = '0;
    logic                done;
    result_t             result;

    sorted_key_table_binary_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .count_we    (count_we),
        .count_wdata (count_wdata),
        .done        (done),
        .result      (result)
    );

    // predictor state: the table as the block holds it, and the active count
    logic [KEY_W-1:0]    key_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0]  table_count = '0;
    // table as the stimulus generator expects it once queued writes land
    logic [KEY_W-1:0]    plan_keys [TABLE_DEPTH];

    item_t               pending_cmds [$];
    result_t             expected_lookups [$];
    int                  err_count   = 0;
    logic                item_taken  = 1'b0;
    int                  burst_left  = 0;
    int                  idle_left   = 0;
    logic                send_next;
    item_t               next_cmd;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic result_t predict_lookup(logic [SKEY_W-1:0] skey);
        result_t r;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        r  = '0;
        n  = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if ({8'h00, key_mem[mid]} == skey)
            begin
                r.found    = 1'b1;
                r.position = mid[7:0];
                return r;
            end
            else if ({8'h00, key_mem[mid]} > skey)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    task automatic flag_error(string what, logic [31:0] expv, logic [31:0] gotv);
        err_count++;
        if (err_count <= 40)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, expv, gotv);
    endtask

    // driver: bursts of transactions with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(start && !item_taken))
        begin
            send_next = 1'b0;
            next_cmd  = item;
            if (idle_left > 0)
                idle_left--;
            else if (pending_cmds.size() > 0)
            begin
                next_cmd  = pending_cmds.pop_front();
                send_next = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 20);
                    idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left--;
            end
            start <= send_next;
            item  <= next_cmd;
        end
    end

    // monitor: check results first, they belong to older transactions
    always @(posedge clk)
    begin
        result_t exp_r;
        if (done)
        begin
            if (expected_lookups.size() == 0)
            begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t: unexpected result, expected none got found %0d position %0d",
                             $time, result.found, result.position);
            end
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (result.found !== exp_r.found)
                    flag_error("found", exp_r.found, result.found);
                if (result.position !== exp_r.position)
                    flag_error("position", exp_r.position, result.position);
            end
        end
        item_taken = rst_n && start && !busy;
        if (item_taken)
        begin
            if (item.action == ACT_SEARCH)
                expected_lookups.push_back(
                    predict_lookup({item.search_high, 8'h00, item.search_low}));
            else
                key_mem[item.entry_index] = {item.entry_upper, item.entry_lower};
        end
    end

    task automatic queue_write(logic [7:0] idx, logic [KEY_W-1:0] key);
        item_t c;
        c             = '0;
        c.action      = ACT_WRITE;
        c.entry_index = idx;
        c.entry_upper = key[23:16];
        c.entry_lower = key[15:0];
        c.search_high = 16'($urandom);
        c.search_low  = 8'($urandom);
        plan_keys[idx] = key;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_search(logic [15:0] hi, logic [7:0] lo);
        item_t c;
        c             = '0;
        c.action      = ACT_SEARCH;
        c.entry_index = 8'($urandom);
        c.entry_upper = 8'($urandom);
        c.entry_lower = 16'($urandom);
        c.search_high = hi;
        c.search_low  = lo;
        pending_cmds.push_back(c);
    endtask

    // ascending keys, many with bits 15..8 clear so that lookups can hit
    task automatic queue_refill();
        logic [31:0] k;
        int          r;
        k = $urandom_range(0, 3);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i > 0)
            begin
                r = $urandom_range(0, 7);
                if (r < 5)
                    k = k + $urandom_range(1, 40);
                else if (r == 5)
                    k = (((k >> 16) + 1) << 16) | $urandom_range(0, 255);
                else if (r == 6)
                    k = k + ($urandom_range(1, 255) << 8);
                else
                    k = k + 1;
                if (k[15:8] != 8'h00 && $urandom_range(0, 1) == 1)
                    k = (((k >> 16) + 1) << 16) | $urandom_range(0, 15);
            end
            // past the top the key wraps and the tail is out of order
            queue_write(i[7:0], k[23:0]);
        end
    endtask

    task automatic queue_mixed(int n_items);
        int               eff;
        int               r;
        int               idx;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] key;
        eff = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                idx = $urandom_range(0, TABLE_DEPTH - 1);
                key = plan_keys[idx];
                if ($urandom_range(0, 9) >= 7)
                    key = 24'($urandom);
                else if (idx > 0 && idx < TABLE_DEPTH - 1 &&
                         plan_keys[idx + 1] > plan_keys[idx - 1] + 24'd1)
                    key = 24'($urandom_range(plan_keys[idx - 1] + 1, plan_keys[idx + 1] - 1));
                queue_write(idx[7:0], key);
            end
            else
            begin
                idx = (eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 255);
                k   = plan_keys[idx];
                if (r < 60)
                    queue_search({8'h00, k[23:16]}, k[7:0]);
                else if (r < 78)
                begin
                    k = ($urandom_range(0, 1) == 1) ? k + 24'd1 : k - 24'd1;
                    queue_search({8'h00, k[23:16]}, k[7:0]);
                end
                else if (r < 88)
                    queue_search(16'($urandom), 8'($urandom));
                else
                    queue_search(16'($urandom_range(0, 255)), 8'($urandom));
            end
        end
    endtask

    // sender holds off until the block is drained and quiet
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || expected_lookups.size() != 0 || busy);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] v);
        @(negedge clk);
        count_we    <= 1'b1;
        count_wdata <= v;
        table_count  = v;
        @(negedge clk);
        count_we    <= 1'b0;
    endtask

    initial
    begin
        int phase_counts [13];
        int cnt;
        phase_counts = '{1, 256, 2, 511, 3, 0, 257, -1, 300, 128, -1, 256, 1};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count is zero out of reset: lookups never match
        queue_search(16'h0000, 8'h00);
        queue_search(16'hFFFF, 8'hFF);
        queue_write(8'd0, 24'h000000);
        queue_write(8'd1, 24'h000001);
        queue_write(8'd2, 24'h0000FF);
        queue_write(8'd3, 24'h00FF00);
        queue_write(8'd4, 24'h010000);
        queue_write(8'd5, 24'h7F0080);
        queue_write(8'd6, 24'hFF00FF);
        queue_write(8'd7, 24'hFFFFFF);
        queue_write(8'd255, 24'hFFFFFF);
        wait_quiet();
        set_count(9'd8);
        queue_search(16'h0000, 8'h00);
        queue_search(16'h0000, 8'hFF);
        queue_search(16'h0001, 8'h00);
        queue_search(16'h007F, 8'h80);
        queue_search(16'h00FF, 8'hFF);
        queue_search(16'h0000, 8'h02);
        queue_search(16'h00FF, 8'h00);
        // keys with bits above 23 set cannot match
        queue_search(16'h0100, 8'h00);
        queue_search(16'hFFFF, 8'hFF);

        for (int p = 0; p < 13; p++)
        begin
            if (p == 0 || p == 4 || p == 8 || p == 11)
                queue_refill();
            wait_quiet();
            cnt = (phase_counts[p] < 0) ? $urandom_range(4, 255) : phase_counts[p];
            set_count(cnt[COUNT_W-1:0]);
            queue_mixed(75);
        end
        wait_quiet();

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
